FILE: rtl/wsht_pkg.sv
// ----------------------------------------------------------------------------
// wsht_pkg
// Shared constants and controller/datapath interface types for the window
// stack hit test block.
// ----------------------------------------------------------------------------
package wsht_pkg;

  localparam int MAX_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int NUM_BITS        = 5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CLICK = 1'b1;

  typedef struct packed {
    logic capture;  // latch the input beat and register the compare vector
    logic commit;   // pick, move to front or push, and write the result
  } cmd_t;

  typedef struct packed {
    logic out_free; // result register can take a beat this cycle
  } status_t;

endpackage

FILE: rtl/wsht_ctrl.sv
// ----------------------------------------------------------------------------
// wsht_ctrl
// Sequencer: accepts one input beat, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
module wsht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output wsht_pkg::cmd_t    cmd,
  input  wsht_pkg::status_t status
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.commit  = (state == S_UPDATE) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_UPDATE;
            in_stall <= 1'b1;
          end
        end
        S_UPDATE: begin
          // hold until the result register drains
          if (status.out_free) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/wsht_datapath.sv
// ----------------------------------------------------------------------------
// wsht_datapath
// Window rectangle registers, parallel point compare, topmost-hit pick,
// move-to-front shift and the result register.
// ----------------------------------------------------------------------------
module wsht_datapath #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wsht_pkg::cmd_t                 cmd,
  output wsht_pkg::status_t              status,
  input  logic                           func,
  input  logic [COORD_BITS-1:0]          coord_x,
  input  logic [COORD_BITS-1:0]          coord_y,
  input  logic [COORD_BITS-1:0]          far_x,
  input  logic [COORD_BITS-1:0]          far_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [wsht_pkg::NUM_BITS-1:0]  window_number,
  output logic                           full_res
);

  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int NB    = wsht_pkg::NUM_BITS;

  // window stack, bottom at index 0
  logic [COORD_BITS-1:0] left   [MAX_WINDOWS];
  logic [COORD_BITS-1:0] bottom [MAX_WINDOWS];
  logic [COORD_BITS-1:0] right  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] top    [MAX_WINDOWS];
  logic [NB-1:0]         number [MAX_WINDOWS];
  logic [CNT_W-1:0]      count;

  // captured beat
  logic                  func_q;
  logic [COORD_BITS-1:0] cx_q;
  logic [COORD_BITS-1:0] cy_q;
  logic [COORD_BITS-1:0] fx_q;
  logic [COORD_BITS-1:0] fy_q;
  logic [MAX_WINDOWS-1:0] hv;

  logic [MAX_WINDOWS-1:0] hv_next;
  logic [MAX_WINDOWS-1:0] pick;
  logic [MAX_WINDOWS-1:0] ge;
  logic                   any_hit;
  logic                   is_full;
  logic [NB-1:0]          new_number;

  logic [COORD_BITS-1:0] pk_left;
  logic [COORD_BITS-1:0] pk_bottom;
  logic [COORD_BITS-1:0] pk_right;
  logic [COORD_BITS-1:0] pk_top;
  logic [NB-1:0]         pk_number;

  logic [COORD_BITS-1:0] nx_left   [MAX_WINDOWS];
  logic [COORD_BITS-1:0] nx_bottom [MAX_WINDOWS];
  logic [COORD_BITS-1:0] nx_right  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] nx_top    [MAX_WINDOWS];
  logic [NB-1:0]         nx_number [MAX_WINDOWS];

  assign status.out_free = !out_valid || !out_stall;
  assign is_full    = (count == CNT_W'(MAX_WINDOWS));
  assign new_number = NB'({1'b0, count} + (CNT_W + 1)'(1));
  assign any_hit    = |hv;

  // parallel inclusive compare against every live window
  always_comb begin
    for (int k = 0; k < MAX_WINDOWS; k++) begin
      hv_next[k] = (CNT_W'(k) < count) &&
                   (left[k] <= coord_x) && (coord_x <= right[k]) &&
                   (bottom[k] <= coord_y) && (coord_y <= top[k]);
    end
  end

  // topmost hit wins; ge marks the picked slot and everything above it
  always_comb begin
    logic above;
    logic seen;
    above = 1'b0;
    for (int k = MAX_WINDOWS - 1; k >= 0; k--) begin
      pick[k] = hv[k] && !above;
      above   = above || hv[k];
    end
    seen = 1'b0;
    for (int k = 0; k < MAX_WINDOWS; k++) begin
      seen  = seen || pick[k];
      ge[k] = seen;
    end
  end

  always_comb begin
    pk_left   = '0;
    pk_bottom = '0;
    pk_right  = '0;
    pk_top    = '0;
    pk_number = '0;
    for (int k = 0; k < MAX_WINDOWS; k++) begin
      pk_left   = pk_left   | (left[k]   & {COORD_BITS{pick[k]}});
      pk_bottom = pk_bottom | (bottom[k] & {COORD_BITS{pick[k]}});
      pk_right  = pk_right  | (right[k]  & {COORD_BITS{pick[k]}});
      pk_top    = pk_top    | (top[k]    & {COORD_BITS{pick[k]}});
      pk_number = pk_number | (number[k] & {NB{pick[k]}});
    end
  end

  // shift source: the slot above, or the picked window for the top slot
  for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_shift
    if (g < MAX_WINDOWS - 1) begin : g_mid
      logic last;
      assign last         = (CNT_W'(g + 1) == count);
      assign nx_left[g]   = last ? pk_left   : left[g + 1];
      assign nx_bottom[g] = last ? pk_bottom : bottom[g + 1];
      assign nx_right[g]  = last ? pk_right  : right[g + 1];
      assign nx_top[g]    = last ? pk_top    : top[g + 1];
      assign nx_number[g] = last ? pk_number : number[g + 1];
    end else begin : g_top
      assign nx_left[g]   = pk_left;
      assign nx_bottom[g] = pk_bottom;
      assign nx_right[g]  = pk_right;
      assign nx_top[g]    = pk_top;
      assign nx_number[g] = pk_number;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      cx_q   <= coord_x;
      cy_q   <= coord_y;
      fx_q   <= far_x;
      fy_q   <= far_y;
      hv     <= hv_next;
    end
    if (cmd.commit) begin
      if (func_q == wsht_pkg::FUNC_LOAD) begin
        for (int k = 0; k < MAX_WINDOWS; k++) begin
          if (!is_full && CNT_W'(k) == count) begin
            left[k]   <= cx_q;
            bottom[k] <= cy_q;
            right[k]  <= fx_q;
            top[k]    <= fy_q;
            number[k] <= new_number;
          end
        end
      end else if (any_hit) begin
        for (int k = 0; k < MAX_WINDOWS; k++) begin
          if (ge[k] && CNT_W'(k) < count) begin
            left[k]   <= nx_left[k];
            bottom[k] <= nx_bottom[k];
            right[k]  <= nx_right[k];
            top[k]    <= nx_top[k];
            number[k] <= nx_number[k];
          end
        end
      end
      hit           <= (func_q == wsht_pkg::FUNC_CLICK) && any_hit;
      window_number <= (func_q == wsht_pkg::FUNC_CLICK) ? pk_number : '0;
      full_res      <= (func_q == wsht_pkg::FUNC_LOAD) && is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit && func_q == wsht_pkg::FUNC_LOAD && !is_full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        // drop the beat once taken
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/window_stack_hit_test.sv
// The beat is registered on accept; the result register is written once it is free.
// No new item is taken until the last one commits; accept compares the point against
// every window in parallel, the update step picks the topmost hit and shifts the stack.
// A waiting result stalls only the update cycle, not the result register's drain.
// Reset clears the window count and the handshake; rectangle registers are not cleared.
// ----------------------------------------------------------------------------
// window_stack_hit_test
// Z-ordered window stack: loads push rectangles, clicks hit-test from the top
// and move the hit window to the front.
// ----------------------------------------------------------------------------
module window_stack_hit_test #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [COORD_BITS-1:0]         coord_x,
  input  logic [COORD_BITS-1:0]         coord_y,
  input  logic [COORD_BITS-1:0]         far_x,
  input  logic [COORD_BITS-1:0]         far_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [wsht_pkg::NUM_BITS-1:0] window_number,
  output logic                          full_res
);

  wsht_pkg::cmd_t    cmd;
  wsht_pkg::status_t status;

  wsht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  wsht_datapath #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .far_x         (far_x),
    .far_y         (far_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .window_number (window_number),
    .full_res      (full_res)
  );

endmodule
